@@ hdl/basic_block_trace_order_unit_defines.svh @@
`ifndef BASIC_BLOCK_TRACE_ORDER_UNIT_DEFINES_SVH
`define BASIC_BLOCK_TRACE_ORDER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define BBTO_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during rst.
`define BBTO_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ hdl/bbto_pkg.sv @@
`default_nettype none

package bbto_pkg;

  // Block ending kinds
  localparam logic [1:0] KIND_FALL = 2'd0;
  localparam logic [1:0] KIND_JUMP = 2'd1;
  localparam logic [1:0] KIND_COND = 2'd2;
  localparam logic [1:0] KIND_RSVD = 2'd3;

  // Result error codes
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_DUPLICATE    = 3'd1;
  localparam logic [2:0] ERR_UNKNOWN      = 3'd2;
  localparam logic [2:0] ERR_FALSE_PLACED = 3'd3;
  localparam logic [2:0] ERR_TOO_MANY     = 3'd4;

  // One result transaction
  typedef struct packed {
    logic       strobe;
    logic [5:0] block_index;
    logic [2:0] error_code;
    logic       last_result;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/basic_block_trace_order_unit.sv @@
`default_nettype none
`include "basic_block_trace_order_unit_defines.svh"

// Channel   Handshake                 Payload
// -------   -----------------------   -------------------------------------------
// block in  start & !busy             block_label, end_kind, target_label, last_block
// result    strobe (one cycle)        block_index, error_code, last_result
//
// Loading a block is a label store lookup, then a write back.
// The run on the last block resolves the targets of jump blocks, scans the
// blocks in two passes that place the traces one block per step, then clears
// the labels of the loaded blocks.
// After rst all LABEL_IDS label store entries are swept once with busy high.
// Results leave on strobe and cannot be held off; busy stays high for the run.

module basic_block_trace_order_unit import bbto_pkg::*; #(
  parameter int MAX_BLOCKS = 64,
  parameter int LABEL_IDS  = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [9:0] block_label,
  input  wire logic [1:0] end_kind,
  input  wire logic [9:0] target_label,
  input  wire logic       last_block,
  output logic            strobe,
  output logic [5:0]      block_index,
  output logic [2:0]      error_code,
  output logic            last_result
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int LW = $clog2(LABEL_IDS);
  localparam int BW = 2 + 2 * LW + IW;

  // label modulo LABEL_IDS by restoring subtraction of scaled multiples
  function automatic logic [LW-1:0] label_reduce(input logic [9:0] v);
    logic [9:0]  r;
    logic [31:0] thr;
    r = v;
    for (int k = 5; k >= 0; k--) begin
      thr = 32'(LABEL_IDS) << k;
      if (32'(r) >= thr) begin
        r = r - thr[9:0];
      end
    end
    return LW'(r);
  endfunction

  logic [LW-1:0] label_red;
  logic [LW-1:0] target_red;
  result_t       res;

  logic          l_we, l_re;
  logic [LW-1:0] l_waddr, l_raddr;
  logic [IW:0]   l_wdata, l_rdata;
  logic          b_we, b_re;
  logic [IW-1:0] b_waddr, b_raddr;
  logic [BW-1:0] b_wdata, b_rdata;

  assign label_red  = label_reduce(block_label);
  assign target_red = label_reduce(target_label);

  bbto_ram #(.DEPTH(LABEL_IDS), .WIDTH(IW + 1)) u_label_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .re    (l_re),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  bbto_ram #(.DEPTH(MAX_BLOCKS), .WIDTH(BW)) u_block_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (b_re),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  bbto_ctrl #(.MAX_BLOCKS(MAX_BLOCKS), .LABEL_IDS(LABEL_IDS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .label_in  (label_red),
    .kind_in   (end_kind),
    .target_in (target_red),
    .last_in   (last_block),
    .busy      (busy),
    .res       (res),
    .l_we      (l_we),
    .l_waddr   (l_waddr),
    .l_wdata   (l_wdata),
    .l_re      (l_re),
    .l_raddr   (l_raddr),
    .l_rdata   (l_rdata),
    .b_we      (b_we),
    .b_waddr   (b_waddr),
    .b_wdata   (b_wdata),
    .b_re      (b_re),
    .b_raddr   (b_raddr),
    .b_rdata   (b_rdata)
  );

  assign strobe      = res.strobe;
  assign block_index = res.block_index;
  assign error_code  = res.error_code;
  assign last_result = res.last_result;

  // results come only from a run in progress
  `BBTO_ASSERT_NOW(a_strobe_busy, strobe, busy, "result transaction while idle")
  // an error always closes the run
  `BBTO_ASSERT_NOW(a_err_last, strobe && (error_code != ERR_NONE), last_result,
                   "error result not marked last")
  // nothing follows the final result directly
  `BBTO_ASSERT_NEXT(a_last_gap, strobe && last_result, !strobe,
                    "result right after final result")
  // a plain load produces no result
  `BBTO_ASSERT_NEXT(a_load_quiet, start && !busy && !last_block, !strobe,
                    "result after non-final block load")

endmodule

`default_nettype wire

@@ hdl/bbto_ram.sv @@
`default_nettype none

// Simple dual-port RAM, registered read with enable.
module bbto_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/bbto_ctrl.sv @@
`default_nettype none

// Sequencer: load, target resolve, two trace passes, label cleanup.
module bbto_ctrl import bbto_pkg::*; #(
  parameter int MAX_BLOCKS = 64,
  parameter int LABEL_IDS  = 1024,
  localparam int IW = $clog2(MAX_BLOCKS),
  localparam int LW = $clog2(LABEL_IDS),
  localparam int BW = 2 + 2 * LW + IW
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [LW-1:0] label_in,
  input  wire logic [1:0]    kind_in,
  input  wire logic [LW-1:0] target_in,
  input  wire logic          last_in,
  output logic               busy,
  output result_t            res,
  // label store: {known, slot}
  output logic               l_we,
  output logic [LW-1:0]      l_waddr,
  output logic [IW:0]        l_wdata,
  output logic               l_re,
  output logic [LW-1:0]      l_raddr,
  input  wire logic [IW:0]   l_rdata,
  // block store: {kind, target, label, target slot}
  output logic               b_we,
  output logic [IW-1:0]      b_waddr,
  output logic [BW-1:0]      b_wdata,
  output logic               b_re,
  output logic [IW-1:0]      b_raddr,
  input  wire logic [BW-1:0] b_rdata
);

  localparam int CW    = $clog2(MAX_BLOCKS + 1);
  localparam int LB_LO = IW;
  localparam int TG_LO = IW + LW;
  localparam int KD_LO = IW + 2 * LW;

  typedef enum logic [12:0] {
    S_RST_CLR  = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_LOAD     = 13'b0000000000100,
    S_RUN      = 13'b0000000001000,
    S_CHK_RD   = 13'b0000000010000,
    S_CHK_LBL  = 13'b0000000100000,
    S_CHK_TST  = 13'b0000001000000,
    S_SCAN_RD  = 13'b0000010000000,
    S_SCAN_TST = 13'b0000100000000,
    S_STEP     = 13'b0001000000000,
    S_FINISH   = 13'b0010000000000,
    S_CLR_RD   = 13'b0100000000000,
    S_CLR_WR   = 13'b1000000000000
  } state_t;

  state_t                state, state_next;
  logic [LW-1:0]         clr_cnt, clr_cnt_next;
  logic [CW-1:0]         count, count_next;
  logic                  too_many, too_many_next;
  logic                  duplicate, duplicate_next;
  logic [LW-1:0]         lbl, lbl_next;
  logic [1:0]            kind, kind_next;
  logic [LW-1:0]         tgt, tgt_next;
  logic                  last, last_next;
  logic [IW-1:0]         idx, idx_next;
  logic [IW-1:0]         cur, cur_next;
  logic                  pass, pass_next;
  logic [MAX_BLOCKS-1:0] placed, placed_next;
  logic                  pend_v, pend_v_next;
  logic [IW-1:0]         pend_idx, pend_idx_next;
  logic [2:0]            pend_err, pend_err_next;

  logic [CW-1:0] count_m1;
  logic [IW-1:0] last_idx;
  logic [1:0]    bd_kind;
  logic [LW-1:0] bd_tgt;
  logic [LW-1:0] bd_lbl;
  logic [IW-1:0] bd_tslot;
  logic          bd_jumps;
  logic          tslot_placed;

  // step-to-next-block results for the check and scan sweeps
  state_t        chk_state;
  logic [IW-1:0] chk_idx;
  state_t        scan_state;
  logic [IW-1:0] scan_idx;
  logic          scan_pass;

  assign count_m1 = count - CW'(1);
  assign last_idx = count_m1[IW-1:0];

  assign bd_kind  = b_rdata[KD_LO +: 2];
  assign bd_tgt   = b_rdata[TG_LO +: LW];
  assign bd_lbl   = b_rdata[LB_LO +: LW];
  assign bd_tslot = b_rdata[IW-1:0];
  assign bd_jumps = (bd_kind == KIND_JUMP) || (bd_kind == KIND_COND);
  // cur is set placed in this same step, so a self loop counts as placed
  assign tslot_placed = placed[bd_tslot] || (bd_tslot == cur);

  assign busy = (state != S_IDLE);

  // sweep advance
  always_comb begin
    if (idx == last_idx) begin
      chk_state = S_SCAN_RD;
      chk_idx   = '0;
    end else begin
      chk_state = S_CHK_RD;
      chk_idx   = idx + IW'(1);
    end
    scan_pass = pass;
    if (idx == last_idx) begin
      scan_idx = '0;
      if (!pass) begin
        scan_state = S_SCAN_RD;
        scan_pass  = 1'b1;
      end else begin
        scan_state = S_FINISH;
      end
    end else begin
      scan_state = S_SCAN_RD;
      scan_idx   = idx + IW'(1);
    end
  end

  // next state and memory port control
  always_comb begin
    state_next     = state;
    clr_cnt_next   = clr_cnt;
    count_next     = count;
    too_many_next  = too_many;
    duplicate_next = duplicate;
    lbl_next       = lbl;
    kind_next      = kind;
    tgt_next       = tgt;
    last_next      = last;
    idx_next       = idx;
    cur_next       = cur;
    pass_next      = pass;
    placed_next    = placed;
    pend_v_next    = pend_v;
    pend_idx_next  = pend_idx;
    pend_err_next  = pend_err;

    l_we    = 1'b0;
    l_waddr = lbl;
    l_wdata = '0;
    l_re    = 1'b0;
    l_raddr = label_in;
    b_we    = 1'b0;
    b_waddr = idx;
    b_wdata = '0;
    b_re    = 1'b0;
    b_raddr = idx;
    res     = '0;

    unique case (state)
      S_RST_CLR: begin
        l_we         = 1'b1;
        l_waddr      = clr_cnt;
        clr_cnt_next = clr_cnt + LW'(1);
        if (clr_cnt == LW'(LABEL_IDS - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          l_re      = 1'b1;
          lbl_next  = label_in;
          kind_next = (kind_in == KIND_RSVD) ? KIND_FALL : kind_in;
          tgt_next  = target_in;
          last_next = last_in;
          if (count == CW'(MAX_BLOCKS)) begin
            too_many_next = 1'b1;
            state_next    = last_in ? S_RUN : S_IDLE;
          end else begin
            state_next = S_LOAD;
          end
        end
      end

      // label lookup is back: record block, flag reuse of a label
      S_LOAD: begin
        if (l_rdata[IW]) begin
          duplicate_next = 1'b1;
        end
        l_we       = 1'b1;
        l_waddr    = lbl;
        l_wdata    = {1'b1, count[IW-1:0]};
        b_we       = 1'b1;
        b_waddr    = count[IW-1:0];
        b_wdata    = {kind, tgt, lbl, IW'(0)};
        count_next = count + CW'(1);
        state_next = last ? S_RUN : S_IDLE;
      end

      S_RUN: begin
        priority if (too_many) begin
          pend_v_next   = 1'b1;
          pend_idx_next = '0;
          pend_err_next = ERR_TOO_MANY;
          state_next    = S_FINISH;
        end else if (duplicate) begin
          pend_v_next   = 1'b1;
          pend_idx_next = '0;
          pend_err_next = ERR_DUPLICATE;
          state_next    = S_FINISH;
        end else begin
          idx_next   = '0;
          state_next = S_CHK_RD;
        end
      end

      S_CHK_RD: begin
        b_re       = 1'b1;
        state_next = S_CHK_LBL;
      end

      S_CHK_LBL: begin
        if (bd_jumps) begin
          l_re       = 1'b1;
          l_raddr    = bd_tgt;
          state_next = S_CHK_TST;
        end else begin
          idx_next   = chk_idx;
          pass_next  = 1'b0;
          state_next = chk_state;
        end
      end

      // target must be known; store its resolved slot back with the block
      S_CHK_TST: begin
        if (!l_rdata[IW]) begin
          pend_v_next   = 1'b1;
          pend_idx_next = '0;
          pend_err_next = ERR_UNKNOWN;
          state_next    = S_FINISH;
        end else begin
          b_we       = 1'b1;
          b_wdata    = {b_rdata[BW-1:IW], l_rdata[IW-1:0]};
          idx_next   = chk_idx;
          pass_next  = 1'b0;
          state_next = chk_state;
        end
      end

      S_SCAN_RD: begin
        b_re       = 1'b1;
        state_next = S_SCAN_TST;
      end

      // first pass starts traces at conditional jumps only
      S_SCAN_TST: begin
        if (!placed[idx] && (pass || (bd_kind == KIND_COND))) begin
          cur_next   = idx;
          state_next = S_STEP;
        end else begin
          idx_next   = scan_idx;
          pass_next  = scan_pass;
          state_next = scan_state;
        end
      end

      // place cur, release the previous pending result, follow the target
      S_STEP: begin
        placed_next[cur] = 1'b1;
        if (pend_v) begin
          res.strobe      = 1'b1;
          res.block_index = 6'(pend_idx);
          res.error_code  = pend_err;
        end
        pend_v_next   = 1'b1;
        pend_idx_next = cur;
        pend_err_next = ERR_NONE;
        if (bd_jumps && !tslot_placed) begin
          cur_next = bd_tslot;
          b_re     = 1'b1;
          b_raddr  = bd_tslot;
        end else if (bd_jumps && (bd_kind == KIND_COND)) begin
          pend_err_next = ERR_FALSE_PLACED;
          state_next    = S_FINISH;
        end else begin
          idx_next   = scan_idx;
          pass_next  = scan_pass;
          state_next = scan_state;
        end
      end

      S_FINISH: begin
        if (pend_v) begin
          res.strobe      = 1'b1;
          res.block_index = 6'(pend_idx);
          res.error_code  = pend_err;
          res.last_result = 1'b1;
        end
        pend_v_next    = 1'b0;
        placed_next    = '0;
        too_many_next  = 1'b0;
        duplicate_next = 1'b0;
        idx_next       = '0;
        state_next     = S_CLR_RD;
      end

      S_CLR_RD: begin
        b_re       = 1'b1;
        state_next = S_CLR_WR;
      end

      // drop the known mark of each loaded label
      S_CLR_WR: begin
        l_we    = 1'b1;
        l_waddr = bd_lbl;
        if (idx == last_idx) begin
          count_next = '0;
          state_next = S_IDLE;
        end else begin
          idx_next   = idx + IW'(1);
          state_next = S_CLR_RD;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RST_CLR;
      clr_cnt   <= '0;
      count     <= '0;
      too_many  <= 1'b0;
      duplicate <= 1'b0;
      placed    <= '0;
      pend_v    <= 1'b0;
      pass      <= 1'b0;
    end else begin
      state     <= state_next;
      clr_cnt   <= clr_cnt_next;
      count     <= count_next;
      too_many  <= too_many_next;
      duplicate <= duplicate_next;
      placed    <= placed_next;
      pend_v    <= pend_v_next;
      pass      <= pass_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    lbl      <= lbl_next;
    kind     <= kind_next;
    tgt      <= tgt_next;
    last     <= last_next;
    idx      <= idx_next;
    cur      <= cur_next;
    pend_idx <= pend_idx_next;
    pend_err <= pend_err_next;
  end

endmodule

`default_nettype wire
